// ===== hdl/ntp_delay_offset_calc_core_assert.svh =====
// ----------------------------------------------------------------------------
// ntp_delay_offset_calc_core_assert.svh
// Assertion macros shared by the delay/offset calculator.
// ----------------------------------------------------------------------------
`ifndef NTP_DELAY_OFFSET_CALC_CORE_ASSERT_SVH
`define NTP_DELAY_OFFSET_CALC_CORE_ASSERT_SVH

// Check a property while out of reset.
`define NDOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define NDOC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/ndoc_pkg.sv =====
// ----------------------------------------------------------------------------
// ndoc_pkg
// Types and constants of the NTP delay/offset calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ndoc_pkg;

  // Field widths
  localparam int unsigned SecW    = 32;
  localparam int unsigned FracW   = 32;
  localparam int unsigned SubW    = 30;  // sub-second nanoseconds, below 10^9
  localparam int unsigned DiffW   = 34;  // signed combination of four seconds
  localparam int unsigned DivW    = 29;  // dividend of the divide-by-125 unit
  localparam int unsigned QuotW   = 23;  // quotient of the divide-by-125 unit
  localparam int unsigned WideW   = 55;  // signed microsecond accumulator
  localparam int unsigned ResW    = 53;
  localparam int unsigned NumLanes = 4;

  // Lane order of the timestamps
  localparam int unsigned LaneOrigin      = 0;
  localparam int unsigned LaneReceive     = 1;
  localparam int unsigned LaneTransmit    = 2;
  localparam int unsigned LaneDestination = 3;

  // Arithmetic constants
  localparam logic [29:0] NsPerSec    = 30'd1000000000;
  localparam logic [31:0] SubBias     = 32'd2000000000;   // multiple of 2000
  localparam logic [29:0] Recip125    = 30'd549755813;    // floor(2^36 / 125)
  localparam int unsigned RecipShift  = 36;
  localparam logic [6:0]  Div125      = 7'd125;
  localparam logic [19:0] UsPerSec    = 20'd1000000;      // delay: 10^9 / 1000
  localparam logic [19:0] HalfUsPerSec = 20'd500000;      // offset: 10^9 / 2000
  localparam logic signed [24:0] DlyQuotBias = 25'sd2000000; // SubBias / 1000
  localparam logic signed [24:0] OffQuotBias = 25'sd1000000; // SubBias / 2000

  // One timestamp split into seconds and sub-second nanoseconds
  typedef struct packed {
    logic [SecW-1:0] sec;
    logic [SubW-1:0] sub;
  } ts_t;

  // Quotient and remainder flag of the divide-by-125 unit
  typedef struct packed {
    logic [QuotW-1:0] quot;
    logic             rem_nz;
  } div_res_t;

  // Load enables of the pipeline stages
  typedef struct packed {
    logic lane;
    logic merge;
    logic div_a;
    logic div_b;
    logic sum;
    logic out;
  } pipe_en_t;

endpackage

// ===== hdl/ndoc_if.sv =====
// ----------------------------------------------------------------------------
// ndoc_if
// Valid/ready channels of the NTP delay/offset calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ndoc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] origin_seconds;
  logic [31:0] origin_fraction;
  logic [31:0] receive_seconds;
  logic [31:0] receive_fraction;
  logic [31:0] transmit_seconds;
  logic [31:0] transmit_fraction;
  logic [31:0] destination_seconds;
  logic [31:0] destination_fraction;

  modport source (
    output valid, origin_seconds, origin_fraction, receive_seconds, receive_fraction,
           transmit_seconds, transmit_fraction, destination_seconds, destination_fraction,
    input  ready
  );
  modport sink (
    input  valid, origin_seconds, origin_fraction, receive_seconds, receive_fraction,
           transmit_seconds, transmit_fraction, destination_seconds, destination_fraction,
    output ready
  );
endinterface

interface ndoc_out_if;
  logic               valid;
  logic               ready;
  logic [52:0]        round_trip_delay_us;
  logic signed [52:0] clock_offset_us;
  logic               result_ok;

  modport source (
    output valid, round_trip_delay_us, clock_offset_us, result_ok,
    input  ready
  );
  modport sink (
    input  valid, round_trip_delay_us, clock_offset_us, result_ok,
    output ready
  );
endinterface

// ===== hdl/ndoc_lane.sv =====
// ----------------------------------------------------------------------------
// ndoc_lane
// One timestamp lane: scale the 2^-32 s fraction to whole nanoseconds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ndoc_lane (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ndoc_pkg::SecW-1:0]  sec_i,
  input  logic [ndoc_pkg::FracW-1:0] frac_i,
  output ndoc_pkg::ts_t             ts_o
);

  localparam int unsigned ProdW = ndoc_pkg::FracW + ndoc_pkg::SubW;

  logic [ProdW-1:0] prod;
  ndoc_pkg::ts_t    ts_q;

  // Fraction times 10^9, keep the integer nanoseconds
  assign prod = ProdW'(frac_i) * ProdW'(ndoc_pkg::NsPerSec);

  // Hold seconds and nanoseconds for the merging stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ts_q.sec <= sec_i;
      ts_q.sub <= prod[ProdW-1:ndoc_pkg::FracW];
    end
  end

  assign ts_o = ts_q;

endmodule

// ===== hdl/ndoc_div125.sv =====
// ----------------------------------------------------------------------------
// ndoc_div125
// Two-stage floor division by 125: reciprocal multiply, then one correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ndoc_div125 (
  input  logic                     clk_i,
  input  logic                     en_a_i,
  input  logic                     en_b_i,
  input  logic [ndoc_pkg::DivW-1:0] v_i,
  input  logic                     low_nz_i,
  output ndoc_pkg::div_res_t       res_o
);

  localparam int unsigned ProdW = ndoc_pkg::DivW + 30;
  localparam int unsigned ChkW  = ndoc_pkg::QuotW + 7;

  logic [ProdW-1:0]           prod;
  logic [ndoc_pkg::QuotW-1:0] q0_q;
  logic [ndoc_pkg::DivW-1:0]  v_q;
  logic                       low_nz_q;
  logic [ChkW-1:0]            chk;
  logic [ndoc_pkg::DivW-1:0]  rem_full;
  logic [7:0]                 rem;
  logic [7:0]                 rem_adj;
  logic [ndoc_pkg::QuotW-1:0] quot;
  ndoc_pkg::div_res_t         res_q;

  // Estimate the quotient; it falls short by at most one
  assign prod = ProdW'(v_i) * ProdW'(ndoc_pkg::Recip125);

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      q0_q     <= prod[ProdW-1:ndoc_pkg::RecipShift];
      v_q      <= v_i;
      low_nz_q <= low_nz_i;
    end
  end

  // Form the remainder and correct the estimate
  always_comb begin
    chk      = ChkW'(q0_q) * ChkW'(ndoc_pkg::Div125);
    rem_full = v_q - chk[ndoc_pkg::DivW-1:0];
    rem      = rem_full[7:0];
    if (rem >= 8'(ndoc_pkg::Div125)) begin
      quot    = q0_q + ndoc_pkg::QuotW'(1);
      rem_adj = rem - 8'(ndoc_pkg::Div125);
    end else begin
      quot    = q0_q;
      rem_adj = rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      res_q.quot   <= quot;
      res_q.rem_nz <= low_nz_q | (rem_adj != 8'd0);
    end
  end

  assign res_o = res_q;

endmodule

// ===== hdl/ndoc_merge.sv =====
// ----------------------------------------------------------------------------
// ndoc_merge
// Merging stage: combine the four lanes into delay and offset in microseconds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ndoc_merge (
  input  logic                        clk_i,
  input  ndoc_pkg::pipe_en_t          en_i,
  input  ndoc_pkg::ts_t               ts_i [ndoc_pkg::NumLanes],
  output logic [ndoc_pkg::ResW-1:0]   delay_us_o,
  output logic signed [ndoc_pkg::ResW-1:0] offset_us_o,
  output logic                        ok_o
);

  localparam int unsigned DW = ndoc_pkg::DiffW;
  localparam int unsigned WW = ndoc_pkg::WideW;
  localparam int unsigned RW = ndoc_pkg::ResW;

  ndoc_pkg::ts_t t1, t2, t3, t4;

  logic [DW-1:0]               ds_sum, os_sum, ud_sum, uo_sum;
  logic signed [DW-1:0]        ds_q, os_q;
  logic [ndoc_pkg::DivW-1:0]   vd_q, vo_q;
  logic                        nzd_q, nzo_q;
  logic signed [WW-1:0]        sd_d, so_d, sd_q, so_q, sd_b_q, so_b_q;
  ndoc_pkg::div_res_t          qd, qo;
  logic signed [24:0]          qd_adj, qo_adj;
  logic signed [WW-1:0]        dly_f_q, off_f_q;
  logic                        off_nz_q;
  logic signed [WW-1:0]        off_t;
  logic                        ok;
  logic [RW-1:0]               delay_q;
  logic signed [RW-1:0]        offset_q;
  logic                        ok_q;

  assign t1 = ts_i[ndoc_pkg::LaneOrigin];
  assign t2 = ts_i[ndoc_pkg::LaneReceive];
  assign t3 = ts_i[ndoc_pkg::LaneTransmit];
  assign t4 = ts_i[ndoc_pkg::LaneDestination];

  // Combine seconds and biased sub-second parts of delay and offset
  assign ds_sum = DW'(t4.sec) - DW'(t1.sec) - DW'(t3.sec) + DW'(t2.sec);
  assign os_sum = DW'(t2.sec) - DW'(t1.sec) + DW'(t3.sec) - DW'(t4.sec);
  assign ud_sum = DW'(t4.sub) - DW'(t1.sub) - DW'(t3.sub) + DW'(t2.sub)
                + DW'(ndoc_pkg::SubBias);
  assign uo_sum = DW'(t2.sub) - DW'(t1.sub) + DW'(t3.sub) - DW'(t4.sub)
                + DW'(ndoc_pkg::SubBias);

  // Split off the power-of-two part of /1000 and /2000
  always_ff @(posedge clk_i) begin
    if (en_i.merge) begin
      ds_q  <= $signed(ds_sum);
      os_q  <= $signed(os_sum);
      vd_q  <= ud_sum[31:3];
      nzd_q <= |ud_sum[2:0];
      vo_q  <= {1'b0, uo_sum[31:4]};
      nzo_q <= |uo_sum[3:0];
    end
  end

  // Scale whole seconds to microseconds
  assign sd_d = WW'(ds_q) * $signed(WW'(ndoc_pkg::UsPerSec));
  assign so_d = WW'(os_q) * $signed(WW'(ndoc_pkg::HalfUsPerSec));

  always_ff @(posedge clk_i) begin
    if (en_i.div_a) begin
      sd_q <= sd_d;
      so_q <= so_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.div_b) begin
      sd_b_q <= sd_q;
      so_b_q <= so_q;
    end
  end

  // Divide the sub-second parts
  ndoc_div125 u_div_dly (
    .clk_i    (clk_i),
    .en_a_i   (en_i.div_a),
    .en_b_i   (en_i.div_b),
    .v_i      (vd_q),
    .low_nz_i (nzd_q),
    .res_o    (qd)
  );

  ndoc_div125 u_div_off (
    .clk_i    (clk_i),
    .en_a_i   (en_i.div_a),
    .en_b_i   (en_i.div_b),
    .v_i      (vo_q),
    .low_nz_i (nzo_q),
    .res_o    (qo)
  );

  // Remove the bias and add to the seconds part: floor quotients
  assign qd_adj = $signed({2'b00, qd.quot}) - ndoc_pkg::DlyQuotBias;
  assign qo_adj = $signed({2'b00, qo.quot}) - ndoc_pkg::OffQuotBias;

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      dly_f_q  <= sd_b_q + WW'(qd_adj);
      off_f_q  <= so_b_q + WW'(qo_adj);
      off_nz_q <= qo.rem_nz;
    end
  end

  // Round the offset toward zero, drop both on a negative delay
  always_comb begin
    ok    = ~dly_f_q[WW-1];
    off_t = off_f_q + WW'({1'b0, off_f_q[WW-1] & off_nz_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.out) begin
      ok_q     <= ok;
      delay_q  <= ok ? dly_f_q[RW-1:0] : '0;
      offset_q <= ok ? off_t[RW-1:0] : '0;
    end
  end

  assign delay_us_o  = delay_q;
  assign offset_us_o = offset_q;
  assign ok_o        = ok_q;

endmodule

// ===== hdl/ntp_delay_offset_calc_core.sv =====
// ----------------------------------------------------------------------------
// ntp_delay_offset_calc_core
// NTP on-wire round-trip delay and clock offset, in microseconds.
// ----------------------------------------------------------------------------
// Channel  | Modport    | Payload
// inp_i    | sink       | four 32.32 timestamps T1..T4 (seconds, fraction)
// res_o    | source     | round_trip_delay_us, clock_offset_us, result_ok
//
// One transaction per cycle sustained while res_o is ready; the result passes
// six register stages: the lane multiply, the merge, the two divide-by-125
// stages, the wide sums and the output register.
// Each stage holds a valid bit and loads whenever it is empty or the next
// stage loads, so bubbles close up and input is taken while a result waits.
// inp_i.ready drops only when all six stages are full and res_o is stalled.
// Reset clears the valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntp_delay_offset_calc_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ndoc_in_if.sink    inp_i,
  ndoc_out_if.source res_o
);

  `include "ntp_delay_offset_calc_core_assert.svh"

  localparam int unsigned NumStages = 6;

  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages-1:0] ld;
  ndoc_pkg::pipe_en_t   en;

  logic [ndoc_pkg::SecW-1:0]  sec  [ndoc_pkg::NumLanes];
  logic [ndoc_pkg::FracW-1:0] frac [ndoc_pkg::NumLanes];
  ndoc_pkg::ts_t              ts   [ndoc_pkg::NumLanes];

  // Stage load enables, from the output back to the input
  always_comb begin
    ld[NumStages-1] = ~vld_q[NumStages-1] | res_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ld[k] = ~vld_q[k] | ld[k+1];
    end
    en.lane  = ld[0];
    en.merge = ld[1];
    en.div_a = ld[2];
    en.div_b = ld[3];
    en.sum   = ld[4];
    en.out   = ld[5];
  end

  // Advance valid bits along the pipeline
  always_comb begin
    vld_d = vld_q;
    if (ld[0]) begin
      vld_d[0] = inp_i.valid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (ld[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign inp_i.ready = ld[0];

  // Route timestamps to lanes
  assign sec[ndoc_pkg::LaneOrigin]       = inp_i.origin_seconds;
  assign frac[ndoc_pkg::LaneOrigin]      = inp_i.origin_fraction;
  assign sec[ndoc_pkg::LaneReceive]      = inp_i.receive_seconds;
  assign frac[ndoc_pkg::LaneReceive]     = inp_i.receive_fraction;
  assign sec[ndoc_pkg::LaneTransmit]     = inp_i.transmit_seconds;
  assign frac[ndoc_pkg::LaneTransmit]    = inp_i.transmit_fraction;
  assign sec[ndoc_pkg::LaneDestination]  = inp_i.destination_seconds;
  assign frac[ndoc_pkg::LaneDestination] = inp_i.destination_fraction;

  for (genvar g = 0; g < ndoc_pkg::NumLanes; g++) begin : g_lane
    ndoc_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en.lane),
      .sec_i  (sec[g]),
      .frac_i (frac[g]),
      .ts_o   (ts[g])
    );
  end

  // Combine lanes into the result
  ndoc_merge u_merge (
    .clk_i       (clk_i),
    .en_i        (en),
    .ts_i        (ts),
    .delay_us_o  (res_o.round_trip_delay_us),
    .offset_us_o (res_o.clock_offset_us),
    .ok_o        (res_o.result_ok)
  );

  assign res_o.valid = vld_q[NumStages-1];

  // Checks
  `NDOC_ASSERT(a_accept_fills, inp_i.valid && inp_i.ready |=> vld_q[0], "accepted transaction lost at entry")
  `NDOC_ASSERT(a_stall_full, !inp_i.ready |-> (&vld_q) && !res_o.ready, "input stalled with room in pipeline")
  `NDOC_ASSERT(a_drop_taken, $fell(vld_q[NumStages-1]) |-> $past(res_o.ready), "result dropped before it was taken")
  `NDOC_ASSERT(a_not_ok_zero, res_o.valid && !res_o.result_ok |-> res_o.round_trip_delay_us == '0 && res_o.clock_offset_us == '0, "fields not cleared on negative delay")

endmodule
